/* design/bee_pkg.sv */
// Shared types, constants and the byte classifier for the backslash escape encoder.
package bee_pkg;

	localparam int MaxChars = 6;
	localparam int CntW = $clog2(MaxChars + 1);
	localparam int IdxW = $clog2(MaxChars);
	localparam int QDepth = 2;
	localparam int QPtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int QCntW = $clog2(QDepth + 1);
	localparam int FlagsW = 9;

	localparam logic [FlagsW-1:0] FlagsReset = 9'd351;

	// configuration register indexes
	typedef enum logic {
		REG_ESCAPE_FLAGS = 1'b0,
		REG_WRAP_QUOTES  = 1'b1
	} reg_idx_t;

	// escape flag bit positions
	localparam int FlgNrt       = 0;
	localparam int FlgSpace     = 1;
	localparam int FlgBackslash = 2;
	localparam int FlgDquote    = 3;
	localparam int FlgSquote    = 4;
	localparam int FlgBacktick  = 5;
	localparam int FlgDollar    = 6;
	localparam int FlgBracket   = 7;
	localparam int FlgOther     = 8;

	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChLf    = 8'h0a;
	localparam logic [7:0] ChCr    = 8'h0d;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChDquote = 8'h22;
	localparam logic [7:0] ChDollar = 8'h24;
	localparam logic [7:0] ChSquote = 8'h27;
	localparam logic [7:0] ChBslash = 8'h5c;
	localparam logic [7:0] ChRbrack = 8'h5d;
	localparam logic [7:0] ChBtick  = 8'h60;
	localparam logic [7:0] ChDel    = 8'h7f;
	localparam logic [7:0] ChLowX   = 8'h78;
	localparam logic [7:0] ChLowN   = 8'h6e;
	localparam logic [7:0] ChLowR   = 8'h72;
	localparam logic [7:0] ChLowT   = 8'h74;

	// one classified item: the characters to send, in order, and how many
	typedef struct packed {
		logic [MaxChars-1:0][7:0] chars;
		logic [CntW-1:0]          cnt;
	} desc_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = 8'h30 + {4'b0, nib};
		end else begin
			r = 8'h57 + {4'b0, nib};
		end
		return r;
	endfunction

	function automatic logic is_plain(input logic [7:0] c);
		logic r;
		r = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
			(c >= 8'h61 && c <= 8'h7a) || c == 8'h25 || c == 8'h2b ||
			c == 8'h2c || c == 8'h2d || c == 8'h2e || c == 8'h2f ||
			c == 8'h3a || c == 8'h40 || c == 8'h5f;
		return r;
	endfunction

	function automatic desc_t classify(input logic [7:0] c, input logic first,
			input logic last, input logic [FlagsW-1:0] flags, input logic wrap);
		desc_t d;
		logic [IdxW-1:0] n;
		logic single;
		logic single_on;
		d.chars = '0;
		n = '0;
		single = 1'b0;
		single_on = 1'b0;
		unique case (c)
			ChSpace:  begin single = 1'b1; single_on = flags[FlgSpace];     end
			ChBslash: begin single = 1'b1; single_on = flags[FlgBackslash]; end
			ChDquote: begin single = 1'b1; single_on = flags[FlgDquote];    end
			ChSquote: begin single = 1'b1; single_on = flags[FlgSquote];    end
			ChBtick:  begin single = 1'b1; single_on = flags[FlgBacktick];  end
			ChDollar: begin single = 1'b1; single_on = flags[FlgDollar];    end
			ChRbrack: begin single = 1'b1; single_on = flags[FlgBracket];   end
			default: begin single = 1'b0; single_on = 1'b0; end
		endcase
		if (wrap && first) begin
			d.chars[n] = ChDquote;
			n = n + 1'b1;
		end
		if (is_plain(c)) begin
			d.chars[n] = c;
			n = n + 1'b1;
		end else if (flags[FlgNrt] && (c == ChCr || c == ChLf || c == ChTab)) begin
			d.chars[n] = ChBslash;
			n = n + 1'b1;
			d.chars[n] = (c == ChCr) ? ChLowR : ((c == ChLf) ? ChLowN : ChLowT);
			n = n + 1'b1;
		end else if (single || (c >= ChSpace && c < ChDel)) begin
			if (single ? single_on : flags[FlgOther]) begin
				d.chars[n] = ChBslash;
				n = n + 1'b1;
			end
			d.chars[n] = c;
			n = n + 1'b1;
		end else begin
			d.chars[n] = ChBslash;
			n = n + 1'b1;
			d.chars[n] = ChLowX;
			n = n + 1'b1;
			d.chars[n] = hex_digit(c[7:4]);
			n = n + 1'b1;
			d.chars[n] = hex_digit(c[3:0]);
			n = n + 1'b1;
		end
		d.cnt = CntW'(n);
		if (wrap && last) begin
			d.chars[n] = ChDquote;
			d.cnt = d.cnt + 1'b1;
		end
		return d;
	endfunction

endpackage

/* design/backslash_escape_encoder.sv */
// Top level of the backslash escape encoder.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | input     | in_valid / in_stall  | in_byte, first_byte, last_byte
//  out     | output    | out_valid / out_stall| out_char, run_end
//  cfg     | input     | cfg_wr_en            | cfg_index, cfg_data
//
// Each byte is classified on entry and queued; the output side sends one
// character per cycle while out_stall is low, all of an item's characters
// in turn, quotes included. Plain bytes flow at one per cycle unless stalled.
// Output is registered; bytes pass through the queue into the output register.
// arst_n clears the queue and output valid and restores register defaults.
// in_stall rises only while the two-entry queue is full.
module backslash_escape_encoder import bee_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_index,
	input  logic [FlagsW-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        in_byte,
	input  logic              first_byte,
	input  logic              last_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_char,
	output logic              run_end
);

	logic  q_full;
	logic  push;
	desc_t push_desc;
	logic  pop;
	logic  head_valid;
	desc_t head_desc;

	bee_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_byte    (in_byte),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.q_full     (q_full),
		.in_stall   (in_stall),
		.push       (push),
		.push_desc  (push_desc)
	);

	bee_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	bee_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.out_stall  (out_stall),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_char   (out_char),
		.run_end    (run_end)
	);

endmodule

/* design/bee_front.sv */
// Front end: configuration registers and byte classification into the queue.
module bee_front import bee_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_index,
	input  logic [FlagsW-1:0] cfg_data,
	input  logic              in_valid,
	input  logic [7:0]        in_byte,
	input  logic              first_byte,
	input  logic              last_byte,
	input  logic              q_full,
	output logic              in_stall,
	output logic              push,
	output desc_t             push_desc
);

	logic [FlagsW-1:0] flags_q;
	logic              wrap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= FlagsReset;
			wrap_q  <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ESCAPE_FLAGS: flags_q <= cfg_data;
				REG_WRAP_QUOTES:  wrap_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_stall  = q_full;
	assign push      = in_valid && !q_full;
	assign push_desc = classify(in_byte, first_byte, last_byte, flags_q, wrap_q);

endmodule

/* design/bee_queue.sv */
// Short queue of classified items between the front and back ends.
module bee_queue import bee_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	input  logic  pop,
	output logic  full,
	output logic  head_valid,
	output desc_t head_desc
);

	desc_t            mem [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;

	function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
		logic [QPtrW-1:0] r;
		if (p == QPtrW'(QDepth - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign full       = (count_q == QCntW'(QDepth));
	assign head_valid = (count_q != '0);
	assign head_desc  = mem[rd_ptr_q];

endmodule

/* design/bee_back.sv */
// Back end: sends head item characters one per cycle unless stalled.
module bee_back import bee_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  desc_t      head_desc,
	input  logic       out_stall,
	output logic       pop,
	output logic       out_valid,
	output logic [7:0] out_char,
	output logic       run_end
);

	logic [IdxW-1:0] idx_q;
	logic            out_valid_q;
	logic [7:0]      out_char_q;
	logic            run_end_q;
	logic            load;
	logic            is_last;

	assign load    = head_valid && (!out_valid_q || !out_stall);
	assign is_last = (CntW'(idx_q) + 1'b1) == head_desc.cnt;
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? '0 : idx_q + 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q <= head_desc.chars[idx_q];
			run_end_q  <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign run_end   = run_end_q;

endmodule

/* bench/bee_checker.sv */
// Checker for the backslash escape encoder: shadows the registers, predicts and compares every char.
module bee_checker import bee_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_index,
	input  logic [FlagsW-1:0] cfg_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [7:0]        in_byte,
	input  logic              first_byte,
	input  logic              last_byte,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [7:0]        out_char,
	input  logic              run_end,
	output int                errors,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] ch;
		logic       tail;
	} esc_char_t;

	esc_char_t         owed_chars [$];
	logic [FlagsW-1:0] flags_sh;
	logic              wrap_sh;

	initial begin
		errors = 0;
		pending = 0;
		flags_sh = FlagsReset;
		wrap_sh = 1'b0;
	end

	task automatic report_mismatch(input string what);
		if (errors < 40) begin
			$display("mismatch at %0t: %s", $realtime, what);
		end
		errors++;
	endtask

	// work out the escaped text of one item and queue it char by char
	task automatic queue_escape(input logic [7:0] c, input logic fst, input logic lst);
		logic [7:0] seq [$];
		logic       guarded;
		logic       guard_on;
		string      hexset;
		hexset = "0123456789abcdef";
		guarded = 1'b1;
		case (c)
			ChSpace:  guard_on = flags_sh[FlgSpace];
			ChBslash: guard_on = flags_sh[FlgBackslash];
			ChDquote: guard_on = flags_sh[FlgDquote];
			ChSquote: guard_on = flags_sh[FlgSquote];
			ChBtick:  guard_on = flags_sh[FlgBacktick];
			ChDollar: guard_on = flags_sh[FlgDollar];
			ChRbrack: guard_on = flags_sh[FlgBracket];
			default: begin
				guarded = 1'b0;
				guard_on = flags_sh[FlgOther];
			end
		endcase
		if (wrap_sh && fst) begin
			seq.push_back(ChDquote);
		end
		if (c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a], 8'h25, 8'h2b, 8'h2c,
				8'h2d, 8'h2e, 8'h2f, 8'h3a, 8'h40, 8'h5f}) begin
			seq.push_back(c);
		end else if (flags_sh[FlgNrt] && c inside {ChCr, ChLf, ChTab}) begin
			seq.push_back(ChBslash);
			seq.push_back(c == ChCr ? ChLowR : (c == ChLf ? ChLowN : ChLowT));
		end else if (guarded || (c >= ChSpace && c < ChDel)) begin
			if (guard_on) begin
				seq.push_back(ChBslash);
			end
			seq.push_back(c);
		end else begin
			seq.push_back(ChBslash);
			seq.push_back(ChLowX);
			seq.push_back(hexset[c[7:4]]);
			seq.push_back(hexset[c[3:0]]);
		end
		if (wrap_sh && lst) begin
			seq.push_back(ChDquote);
		end
		foreach (seq[i]) begin
			owed_chars.push_back('{ch: seq[i], tail: (i == seq.size() - 1)});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		esc_char_t want;
		if (!arst_n) begin
			flags_sh = FlagsReset;
			wrap_sh = 1'b0;
			owed_chars.delete();
			pending = 0;
		end else begin
			// outputs are registered, so a char accepted now never belongs to this edge's item
			if (out_valid && !out_stall) begin
				if (owed_chars.size() == 0) begin
					report_mismatch($sformatf("char %02h arrived with nothing owed", out_char));
				end else begin
					want = owed_chars.pop_front();
					if (out_char !== want.ch) begin
						report_mismatch($sformatf("out_char %02h, expected %02h",
							out_char, want.ch));
					end
					if (run_end !== want.tail) begin
						report_mismatch($sformatf("run_end %b on char %02h, expected %b",
							run_end, out_char, want.tail));
					end
				end
			end
			if (cfg_wr_en) begin
				if (cfg_index == REG_ESCAPE_FLAGS) begin
					flags_sh = cfg_data;
				end else begin
					wrap_sh = cfg_data[0];
				end
			end
			if (in_valid && !in_stall) begin
				queue_escape(in_byte, first_byte, last_byte);
			end
			pending = owed_chars.size();
		end
	end

endmodule

/* bench/tb_backslash_escape_encoder.sv */
// Testbench top for the backslash escape encoder: stimulus, flow control and the verdict.
module tb_backslash_escape_encoder;
	import bee_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int StallLimit = 2000;
	localparam int HoldCycles = 40;
	localparam int PhaseItems = 34;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic              cfg_index = 1'b0;
	logic [FlagsW-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        in_byte = '0;
	logic              first_byte = 1'b0;
	logic              last_byte = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [7:0]        out_char;
	logic              run_end;
	int                errors;
	int                pending;

	int idle_pct = 35;
	bit hold_req = 1'b0;
	int quiet_cycles = 0;

	logic [7:0] dir_bytes [22] = '{8'h00, 8'hff, 8'h61, 8'h5a, 8'h30, 8'h25, 8'h5f, ChCr,
		ChLf, ChTab, ChSpace, ChBslash, ChDquote, ChSquote, ChBtick, ChDollar, ChRbrack,
		8'h21, 8'h7e, ChDel, 8'h80, 8'h1f};
	logic [7:0] odd_bytes [15] = '{ChCr, ChLf, ChTab, ChSpace, ChBslash, ChDquote, ChSquote,
		ChBtick, ChDollar, ChRbrack, ChDel, 8'h21, 8'h7e, 8'h00, 8'hff};

	backslash_escape_encoder dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.in_byte(in_byte), .first_byte(first_byte), .last_byte(last_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_char(out_char), .run_end(run_end)
	);

	bee_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.in_byte(in_byte), .first_byte(first_byte), .last_byte(last_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_char(out_char), .run_end(run_end),
		.errors(errors), .pending(pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
			end else begin
				out_stall <= ($urandom_range(99) < idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= StallLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [FlagsW-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
		int gap;
		gap = ($urandom_range(99) < idle_pct) ? $urandom_range(4, 1) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		first_byte <= f;
		last_byte <= l;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// stop offering items and wait until every owed char has come out
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic send_string(input int len, input bit noisy);
		int         pick;
		logic [7:0] b;
		logic       f;
		logic       l;
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				b = 8'($urandom_range(255));
			end else if (pick < 70) begin
				b = odd_bytes[$urandom_range(14)];
			end else begin
				b = 8'h30 + 8'($urandom_range(74));
			end
			f = noisy ? 1'($urandom_range(1)) : (i == 0);
			l = noisy ? 1'($urandom_range(1)) : (i == len - 1);
			send_byte(b, f, l);
		end
	endtask

	initial begin
		int               sent;
		int               len;
		bit               held;
		bit               paused;
		logic [FlagsW-1:0] fv;
		logic [FlagsW-1:0] wv;
		held = 1'b0;
		paused = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: default flags, quotes on, marks in and out of order
		write_reg(REG_WRAP_QUOTES, 9'h001);
		for (int i = 0; i < 22; i++) begin
			send_byte(dir_bytes[i], (i % 3 == 0), (i % 3 == 2) || (i % 7 == 3));
		end
		settle();

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin fv = 9'h000; wv = 9'h1fe; end // wide value, low bit clear
				1: begin fv = 9'h1ff; wv = 9'h001; end
				default: begin
					fv = FlagsW'($urandom_range(511));
					wv = FlagsW'($urandom_range(511));
				end
			endcase
			write_reg(REG_ESCAPE_FLAGS, fv);
			write_reg(REG_WRAP_QUOTES, wv);
			idle_pct = (ph == 3) ? 0 : 35;
			sent = 0;
			while (sent < PhaseItems) begin
				len = ($urandom_range(99) < 20) ? 1 : $urandom_range(8, 2);
				send_string(len, $urandom_range(99) < 15);
				sent += len;
				if (ph == 2 && !held && sent >= 16) begin
					hold_req = 1'b1;
					held = 1'b1;
				end
				if (ph == 4 && !paused && sent >= 20) begin
					settle();
					paused = 1'b1;
				end
			end
			settle();
		end

		repeat (8) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
